// ----- hw/rtl/rv32_subset_five_stage_pipeline_core_macros.svh -----
// Assertion macros for the five-stage pipeline core.
`ifndef RV32_SUBSET_FIVE_STAGE_PIPELINE_CORE_MACROS_SVH
`define RV32_SUBSET_FIVE_STAGE_PIPELINE_CORE_MACROS_SVH
// Implication checked on every edge outside reset.
`define RV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Implication checked on every edge, reset included.
`define RV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- hw/rtl/rv5p_pkg.sv -----
// ----------------------------------------------------------------------------
// rv5p_pkg
// Shared constants and types of the five-stage pipeline core.
// ----------------------------------------------------------------------------
package rv5p_pkg;
  localparam int unsigned DataDepth = 1024;
  localparam int unsigned DataAw    = $clog2(DataDepth);
  localparam int unsigned PcW       = 16;

  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] F7Alt    = 7'h20;

  typedef enum logic [4:0] {
    K_NOP, K_BEQ, K_BNE, K_BLT, K_BGE, K_LW, K_SW, K_ADDI, K_ORI, K_ANDI,
    K_ADD, K_SUB, K_XOR, K_SRL, K_SRA, K_OR, K_AND
  } kind_e;

  // Write request sent from the core to the data memory unit.
  typedef struct packed {
    logic        store;
    logic [DataAw-1:0] addr;
    logic [31:0] wdata;
  } mem_req_t;

  function automatic kind_e classify(input logic [31:0] w);
    kind_e k;
    k = K_NOP;
    case (w[6:0])
      OpBranch: begin
        case (w[14:12])
          3'd0: k = K_BEQ;
          3'd1: k = K_BNE;
          3'd4: k = K_BLT;
          3'd5: k = K_BGE;
          default: k = K_NOP;
        endcase
      end
      OpLoad:  k = (w[14:12] == 3'd2) ? K_LW : K_NOP;
      OpStore: k = (w[14:12] == 3'd2) ? K_SW : K_NOP;
      OpImm: begin
        case (w[14:12])
          3'd0: k = K_ADDI;
          3'd6: k = K_ORI;
          3'd7: k = K_ANDI;
          default: k = K_NOP;
        endcase
      end
      OpReg: begin
        if (w[31:25] == 7'd0) begin
          case (w[14:12])
            3'd0: k = K_ADD;
            3'd4: k = K_XOR;
            3'd5: k = K_SRL;
            3'd6: k = K_OR;
            3'd7: k = K_AND;
            default: k = K_NOP;
          endcase
        end else if (w[31:25] == F7Alt) begin
          case (w[14:12])
            3'd0: k = K_SUB;
            3'd5: k = K_SRA;
            default: k = K_NOP;
          endcase
        end
      end
      default: k = K_NOP;
    endcase
    return k;
  endfunction
endpackage

// ----- hw/rtl/rv5p_if.sv -----
// ----------------------------------------------------------------------------
// rv5p_if
// Valid/ready channel interfaces for instruction input and result output.
// ----------------------------------------------------------------------------
interface rv5p_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface rv5p_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] fetch_pc;
  logic        wb_valid;
  logic [4:0]  wb_reg;
  logic [31:0] wb_value;
  logic        branch_taken;
  logic        halted;
  modport source (output valid, output fetch_pc, output wb_valid, output wb_reg,
                  output wb_value, output branch_taken, output halted, input ready);
  modport sink   (input valid, input fetch_pc, input wb_valid, input wb_reg,
                  input wb_value, input branch_taken, input halted, output ready);
endinterface

// ----- hw/rtl/rv5p_dmem.sv -----
// ----------------------------------------------------------------------------
// rv5p_dmem
// Data memory: synchronous read, one write port, with a clearing pass after
// reset and write-to-read bypass.
// ----------------------------------------------------------------------------
module rv5p_dmem
  import rv5p_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [rv5p_pkg::DataAw-1:0] raddr_i,
  input  rv5p_pkg::mem_req_t          wreq_i,
  output logic [31:0]                 rdata_o,
  output logic                        busy_o
);
  logic [31:0]       mem_q [DataDepth];
  logic [DataAw:0]   clr_q;
  logic [31:0]       rd_q;
  logic              byp_q;
  logic [31:0]       bypd_q;

  assign busy_o = !clr_q[DataAw];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (busy_o) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      mem_q[clr_q[DataAw-1:0]] <= '0;
    end else if (en_i && wreq_i.store) begin
      mem_q[wreq_i.addr] <= wreq_i.wdata;
    end
    if (en_i) begin
      rd_q   <= mem_q[raddr_i];
      byp_q  <= wreq_i.store && (wreq_i.addr == raddr_i);
      bypd_q <= wreq_i.wdata;
    end
  end

  assign rdata_o = byp_q ? bypd_q : rd_q;
endmodule

// ----- hw/rtl/rv32_subset_five_stage_pipeline_core.sv -----
// ----------------------------------------------------------------------------
// rv32_subset_five_stage_pipeline_core
// Five-stage in-order core for an integer RISC-V subset.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                  Transfer
// in_if     in   instr_word                               valid & ready
// out_if    out  fetch_pc wb_* branch_taken halted        valid & ready
// cfg       in   cfg_start_pc_i                           cfg_we_i
//
// One instruction transfer is taken each cycle, unless the output stalls or
// the clearing pass runs, and yields one result, so the pipeline advances one
// step per transfer. After reset a clearing pass sweeps the data memory and
// the register file, during which no transfer is taken.
// The data memory and register file are synchronous memories; operands and
// load data are read one step ahead, at the address the next step will use.
// A stall on the output holds the whole pipeline; an output register lets
// the next transfer in while a result waits, as long as the slot drains.
`include "rv32_subset_five_stage_pipeline_core_macros.svh"
module rv32_subset_five_stage_pipeline_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_start_pc_i,
  rv5p_in_if.sink     in_if,
  rv5p_out_if.source  out_if
);
  import rv5p_pkg::*;

  // Pipeline latches. Field names follow the stage they feed.
  logic        fd_v_q;  logic [31:0] fd_w_q;  logic [15:0] fd_pc_q;
  logic        de_v_q;  logic [31:0] de_w_q;  logic [15:0] de_pc_q;
  logic        em_v_q;  logic [31:0] em_w_q;  logic em_wen_q;  logic [4:0] em_rd_q;
  logic [31:0] em_res_q; logic em_ld_q; logic em_st_q; logic [31:0] em_sd_q;
  logic        mw_v_q;  logic [31:0] mw_w_q;  logic mw_wen_q;  logic [4:0] mw_rd_q;
  logic [31:0] mw_val_q;
  logic        rt_v_q;  logic [31:0] rt_w_q;
  logic [15:0] pc_q, start_q;
  logic        started_q, halt_q;

  // Register file: written with the writeback latch, read for the next
  // decode/execute instruction. rfa_q/rfb_q are registered reads. It is swept
  // to zero while the data memory is being cleared.
  logic [31:0] rf_q [32];
  logic [31:0] rfa_q, rfb_q;
  logic [4:0]  rfclr_q;

  // Output slot.
  logic        ov_q;
  logic [15:0] opc_q; logic owv_q; logic [4:0] owr_q; logic [31:0] owd_q;
  logic        obr_q, oh_q;

  logic busy, step;
  logic [31:0] mem_rdata;
  mem_req_t    wreq;

  assign in_if.ready = !busy && (!ov_q || out_if.ready);
  assign step = in_if.valid && in_if.ready;

  // ---- execute ----
  kind_e       k;
  logic [4:0]  rs1, rs2, rd;
  logic [31:0] a, b, imm_i, imm_s, imm_b, res;
  logic        taken, wen;
  logic [15:0] target;

  // Operand source: the execute/memory latch (load data from memory), then
  // memory/writeback, then the register file read made on the previous step.
  // The register-file read bypasses the write performed at that edge.
  function automatic logic [31:0] fwd(input logic [4:0] r, input logic [31:0] rfv);
    logic [31:0] v;
    v = rfv;
    if (r == 5'd0) v = '0;
    else if (em_v_q && em_wen_q && em_rd_q == r) v = em_ld_q ? mem_rdata : em_res_q;
    else if (mw_v_q && mw_wen_q && mw_rd_q == r) v = mw_val_q;
    return v;
  endfunction

  always_comb begin
    k     = classify(de_w_q);
    rs1   = de_w_q[19:15];
    rs2   = de_w_q[24:20];
    rd    = de_w_q[11:7];
    a     = fwd(rs1, rfa_q);
    b     = fwd(rs2, rfb_q);
    imm_i = {{20{de_w_q[31]}}, de_w_q[31:20]};
    imm_s = {{20{de_w_q[31]}}, de_w_q[31:25], de_w_q[11:7]};
    imm_b = {{20{de_w_q[31]}}, de_w_q[7], de_w_q[30:25], de_w_q[11:8], 1'b0};
    target = de_pc_q + imm_b[15:0];
    res   = '0;
    taken = 1'b0;
    wen   = rd != 5'd0;
    case (k)
      K_BEQ: begin wen = 1'b0; taken = a == b; end
      K_BNE: begin wen = 1'b0; taken = a != b; end
      K_BLT: begin wen = 1'b0; taken = $signed(a) < $signed(b); end
      K_BGE: begin wen = 1'b0; taken = !($signed(a) < $signed(b)); end
      K_LW:   res = a + imm_i;
      K_SW:   begin wen = 1'b0; res = a + imm_s; end
      K_ADDI: res = a + imm_i;
      K_ORI:  res = a | imm_i;
      K_ANDI: res = a & imm_i;
      K_ADD:  res = a + b;
      K_SUB:  res = a - b;
      K_XOR:  res = a ^ b;
      K_SRL:  res = a >> b[4:0];
      K_SRA:  res = 32'($signed(a) >>> b[4:0]);
      K_OR:   res = a | b;
      K_AND:  res = a & b;
      default: wen = 1'b0;
    endcase
    if (!de_v_q) begin
      taken = 1'b0;
      wen   = 1'b0;
    end
  end

  logic de_take;
  assign de_take = de_v_q && (k == K_LW);

  // Memory request from the current execute/memory latch.
  always_comb begin
    wreq.store = em_v_q && em_st_q;
    wreq.addr  = em_res_q[DataAw+1:2];
    wreq.wdata = em_sd_q;
  end

  // The next load address is known in execute; read it on this step so the
  // data is ready when the load sits in the execute/memory latch.
  rv5p_dmem u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (step && !halt_q),
    .raddr_i (res[DataAw+1:2]),
    .wreq_i  (wreq),
    .rdata_o (mem_rdata),
    .busy_o  (busy)
  );

  // Halt detection on the next latch contents.
  logic fd_v_d, de_v_d, halt_d;
  logic [15:0] pc_d;
  logic wb_now;
  assign fd_v_d = !taken;
  assign de_v_d = fd_v_q && !taken;
  assign pc_d   = taken ? target : pc_q + 16'd4;
  assign halt_d = fd_v_d && in_if.instr_word == '0 && de_v_d && fd_w_q == '0
               && de_v_q && de_w_q == '0 && em_v_q && em_w_q == '0
               && mw_v_q && mw_w_q == '0;
  assign wb_now = mw_v_q && mw_wen_q && mw_rd_q != 5'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_v_q <= 1'b0; de_v_q <= 1'b0; em_v_q <= 1'b0; mw_v_q <= 1'b0;
      rt_v_q <= 1'b0; pc_q <= '0; start_q <= '0; started_q <= 1'b0;
      halt_q <= 1'b0; ov_q <= 1'b0; rfclr_q <= '0;
    end else begin
      if (busy) rfclr_q <= rfclr_q + 5'd1;
      if (cfg_we_i) begin
        start_q <= cfg_start_pc_i;
        if (!started_q) pc_q <= cfg_start_pc_i;
      end
      // The slot fills on a transfer in and empties when the result is taken.
      ov_q <= step || (ov_q && !out_if.ready);
      if (step) begin
        started_q <= 1'b1;
        if (!halt_q) begin
          fd_v_q <= fd_v_d; de_v_q <= de_v_d; em_v_q <= de_v_q;
          mw_v_q <= em_v_q; rt_v_q <= mw_v_q;
          pc_q   <= pc_d;
          halt_q <= halt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy) rf_q[rfclr_q] <= '0;
    if (step && !halt_q) begin
      fd_w_q  <= in_if.instr_word; fd_pc_q <= pc_q;
      de_w_q  <= fd_w_q;           de_pc_q <= fd_pc_q;
      em_w_q  <= de_w_q; em_wen_q <= wen; em_rd_q <= rd; em_res_q <= res;
      em_ld_q <= de_take; em_st_q <= de_v_q && (k == K_SW); em_sd_q <= b;
      mw_w_q  <= em_w_q; mw_wen_q <= em_wen_q; mw_rd_q <= em_rd_q;
      mw_val_q <= em_ld_q ? mem_rdata : em_res_q;
      rt_w_q  <= mw_w_q;
      if (wb_now) rf_q[mw_rd_q] <= mw_val_q;
      // Read operands of the instruction entering decode/execute.
      rfa_q <= (wb_now && mw_rd_q == fd_w_q[19:15]) ? mw_val_q : rf_q[fd_w_q[19:15]];
      rfb_q <= (wb_now && mw_rd_q == fd_w_q[24:20]) ? mw_val_q : rf_q[fd_w_q[24:20]];
    end
    if (step) begin
      opc_q <= halt_q ? pc_q : pc_d;
      owv_q <= !halt_q && wb_now;
      owr_q <= (!halt_q && wb_now) ? mw_rd_q : 5'd0;
      owd_q <= (!halt_q && wb_now) ? mw_val_q : 32'd0;
      obr_q <= !halt_q && taken;
      oh_q  <= halt_q || halt_d;
    end
  end

  assign out_if.valid        = ov_q;
  assign out_if.fetch_pc     = opc_q;
  assign out_if.wb_valid     = owv_q;
  assign out_if.wb_reg       = owr_q;
  assign out_if.wb_value     = owd_q;
  assign out_if.branch_taken = obr_q;
  assign out_if.halted       = oh_q;

  `RV_ASSERT(a_no_step_busy, clk_i, rst_ni, busy |-> !in_if.ready, "transfer during clear")
  `RV_ASSERT(a_halt_sticky, clk_i, rst_ni, halt_q |=> halt_q, "halt flag dropped")
  `RV_ASSERT(a_flush, clk_i, rst_ni, (step && !halt_q && taken) |=> (!fd_v_q && !de_v_q),
             "taken branch did not flush")
  `RV_ASSERT(a_wb_x0, clk_i, rst_ni, (ov_q && out_if.wb_valid) |-> out_if.wb_reg != 5'd0,
             "write to x0 reported")
endmodule
